[design/assert_macros.svh]
// Assertion helpers for the clipper RTL; all sample on i_clk, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge
`define LBC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define LBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared widths, register codes and types for the Liang-Barsky line clipper.
// ----------------------------------------------------------------------------
package lbc_pkg;

    // Coordinate format (Q16.8) and line-parameter fraction bits
    localparam int COORD_BITS      = 24;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int CW = COORD_BITS;
    localparam int FB = PARAM_FRAC_BITS;
    localparam int DW = CW + 1;          // differences of two coordinates
    localparam int QB = FB + 2;          // quotient bits, covers 0..2.0
    localparam int UW = FB + 3;          // signed parameter u in [-1, 2]
    localparam int RW = DW + FB + 2;     // divider remainder
    localparam int PW = UW + DW;         // u * delta
    localparam int OW = PW - FB;         // floored offset
    localparam int SW = OW + 1;          // start + offset before saturation

    localparam logic [UW-1:0] U_ONE = UW'(64'd1 << FB);
    localparam logic [UW-1:0] U_TWO = UW'(64'd2 << FB);
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Configuration register indexes
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_WIN_LEFT   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_WIN_RIGHT  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_WIN_TOP    = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_WIN_BOTTOM = IDX_W'(3);

    // Boundaries in evaluation order
    localparam int NE = 4;
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_TOP    = 2;
    localparam int EDGE_BOTTOM = 3;

    // Decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Segment state carried down the back pipeline
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 prej;   // some parallel boundary rejects
        logic [NE-1:0]        skip;   // boundary parallel to the segment
        logic [NE-1:0]        pneg;   // p < 0: boundary raises entry
    } t_item;

    // Queue entry: segment plus per-boundary q
    typedef struct packed {
        t_item                 item;
        logic [NE-1:0][DW-1:0] q;
    } t_fe_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One boundary's divider slice
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] quo;
        logic [DW-1:0] pmag;
        logic          neg;
        logic          ovf;
    } t_div;

endpackage

[design/liang_barsky_line_clip.sv]
// Path: an accepted segment passes the queue, stage 0, the divider stages,
//   saturate, combine, multiply and the output register that shows its result.
// Throughput: one segment per cycle unless the result beat waits unpopped,
//   sustained by the pipelined ratio dividers, one quotient bit per stage.
// Reset: synchronous, active low; window returns to its reset values and
//   the queue and pipeline are emptied.
// ----------------------------------------------------------------------------
// liang_barsky_line_clip
// Clips a segment against the configured window: classifier front end,
// decoupling queue, and a pipelined divide/combine/multiply back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module liang_barsky_line_clip
    import lbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic signed [CW-1:0] i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    input  logic signed [CW-1:0] i_end_x,
    input  logic signed [CW-1:0] i_end_y,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_visible,
    output logic signed [CW-1:0] o_clip_start_x,
    output logic signed [CW-1:0] o_clip_start_y,
    output logic signed [CW-1:0] o_clip_end_x,
    output logic signed [CW-1:0] o_clip_end_y
);

    t_q_stat  w_q_stat;
    t_fe_item w_q_wdata, w_q_rdata;
    logic     w_q_push, w_q_pop;

    // classifier and window registers
    lbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_q_stat   (w_q_stat),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    // decoupling queue
    lbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    // clip pipeline and result register
    lbc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (w_q_stat),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_visible      (o_visible),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

    // queue consistency
    `LBC_ASSERT(a_q_full_empty, !(w_q_stat.full && w_q_stat.empty), "queue full and empty")
    `LBC_ASSERT(a_q_pop_empty, !(w_q_pop && w_q_stat.empty), "pop from empty queue")
    `LBC_ASSERT_NEXT(a_q_push_fill, w_q_push && !w_q_pop, !w_q_stat.empty, "push lost")

endmodule

[design/lbc_queue.sv]
// ----------------------------------------------------------------------------
// lbc_queue
// Small register queue that decouples the classifier from the clip pipeline.
// ----------------------------------------------------------------------------
module lbc_queue
    import lbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fe_item i_data,
    input  logic     i_pop,
    output t_fe_item o_data,
    output t_q_stat  o_stat
);

    t_fe_item       r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_cnt, n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + QAW'(i_push);
        n_rd_ptr = r_rd_ptr + QAW'(i_pop);
        n_cnt    = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

[design/lbc_front.sv]
// ----------------------------------------------------------------------------
// lbc_front
// Window registers and segment classifier: forms deltas and the four q
// terms, flags parallel boundaries, and pushes the beat into the queue.
// ----------------------------------------------------------------------------
module lbc_front
    import lbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic signed [CW-1:0] i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    input  logic signed [CW-1:0] i_end_x,
    input  logic signed [CW-1:0] i_end_y,
    input  t_q_stat              i_q_stat,
    output logic                 o_q_push,
    output t_fe_item             o_q_data
);

    logic signed [CW-1:0] r_win_left, r_win_right, r_win_top, r_win_bottom;
    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [DW-1:0] w_q [NE];
    logic [NE-1:0]        w_skip, w_pneg, w_qneg;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_right  <= C_MAX;
            r_win_top    <= '0;
            r_win_bottom <= C_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIN_LEFT:   r_win_left   <= i_cfg_data;
                REG_WIN_RIGHT:  r_win_right  <= i_cfg_data;
                REG_WIN_TOP:    r_win_top    <= i_cfg_data;
                REG_WIN_BOTTOM: r_win_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // deltas and boundary distances
    always_comb begin
        w_dx = DW'(i_end_x) - DW'(i_start_x);
        w_dy = DW'(i_end_y) - DW'(i_start_y);
        w_q[EDGE_LEFT]   = DW'(i_start_x) - DW'(r_win_left);
        w_q[EDGE_RIGHT]  = DW'(r_win_right) - DW'(i_start_x);
        w_q[EDGE_TOP]    = DW'(i_start_y) - DW'(r_win_top);
        w_q[EDGE_BOTTOM] = DW'(r_win_bottom) - DW'(i_start_y);
    end

    // classify: parallel boundaries and sign of p
    always_comb begin
        w_skip[EDGE_LEFT]   = (w_dx == '0);
        w_skip[EDGE_RIGHT]  = (w_dx == '0);
        w_skip[EDGE_TOP]    = (w_dy == '0);
        w_skip[EDGE_BOTTOM] = (w_dy == '0);
        w_pneg[EDGE_LEFT]   = (w_dx > 0);
        w_pneg[EDGE_RIGHT]  = (w_dx < 0);
        w_pneg[EDGE_TOP]    = (w_dy > 0);
        w_pneg[EDGE_BOTTOM] = (w_dy < 0);
        for (int e = 0; e < NE; e++) begin
            w_qneg[e] = w_q[e][DW-1];
        end
    end

    always_comb begin
        o_q_data.item.x0   = i_start_x;
        o_q_data.item.y0   = i_start_y;
        o_q_data.item.dx   = w_dx;
        o_q_data.item.dy   = w_dy;
        o_q_data.item.prej = |(w_skip & w_qneg);
        o_q_data.item.skip = w_skip;
        o_q_data.item.pneg = w_pneg;
        for (int e = 0; e < NE; e++) begin
            o_q_data.q[e] = w_q[e];
        end
    end

    assign full     = i_q_stat.full;
    assign o_q_push = push && !i_q_stat.full;

endmodule

[design/lbc_back.sv]
// ----------------------------------------------------------------------------
// lbc_back
// Clip pipeline: per-boundary ratio dividers (one quotient bit per stage),
// saturation, entry/exit combine, multiply, floor and saturate, and the
// output register holding the result beat.
// ----------------------------------------------------------------------------
module lbc_back
    import lbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_stat              i_q_stat,
    input  t_fe_item             i_q_data,
    output logic                 o_q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_visible,
    output logic signed [CW-1:0] o_clip_start_x,
    output logic signed [CW-1:0] o_clip_start_y,
    output logic signed [CW-1:0] o_clip_end_x,
    output logic signed [CW-1:0] o_clip_end_y
);

    // start + floor(prod / 2^FB), saturated to the coordinate range
    function automatic logic [CW-1:0] clip_coord(input logic signed [CW-1:0] s,
                                                 input logic signed [PW-1:0] prod);
        logic signed [OW-1:0] off;
        logic signed [SW-1:0] sum;
        begin
            off = prod[PW-1:FB];
            sum = SW'(s) + SW'(off);
            if (sum > $signed(SW'(C_MAX))) begin
                clip_coord = C_MAX;
            end else if (sum < $signed({{(SW-CW){1'b1}}, C_MIN})) begin
                clip_coord = C_MIN;
            end else begin
                clip_coord = sum[CW-1:0];
            end
        end
    endfunction

    logic en;

    // stage 0: magnitudes and overflow check
    logic  r_s0_v;
    t_item r_s0_item;
    t_div  r_s0_div [NE];
    t_div  n_s0_div [NE];

    // divider stages
    logic [QB-1:0] r_dv_v;
    t_item         r_dv_item [QB];
    t_div          r_dv_div  [QB][NE];
    t_div          n_dv_div  [QB][NE];

    // saturated u
    logic                 r_st_v;
    t_item                r_st_item;
    logic signed [UW-1:0] r_st_u [NE];
    logic signed [UW-1:0] n_st_u [NE];

    // combined bounds
    logic                 r_cb_v, r_cb_ok, n_cb_ok;
    t_item                r_cb_item;
    logic signed [UW-1:0] r_cb_entry, r_cb_exit, n_cb_entry, n_cb_exit;

    // products
    logic                 r_ml_v, r_ml_ok;
    t_item                r_ml_item;
    logic signed [PW-1:0] r_ml_p [NE];

    // output register
    logic                 r_ov, r_o_vis;
    logic [CW-1:0]        r_o_sx, r_o_sy, r_o_ex, r_o_ey;
    logic [CW-1:0]        n_o_sx, n_o_sy, n_o_ex, n_o_ey;

    // whole pipeline advances unless the result beat is stuck
    assign en      = !r_ov || pop;
    assign o_q_pop = en && !i_q_stat.empty;

    // stage 0 logic
    always_comb begin
        logic [DW-1:0] qm;
        logic [DW-1:0] pm;
        for (int e = 0; e < NE; e++) begin
            qm = i_q_data.q[e][DW-1] ? DW'(-i_q_data.q[e]) : i_q_data.q[e];
            if (e == EDGE_LEFT || e == EDGE_RIGHT) begin
                pm = i_q_data.item.dx[DW-1] ? DW'(-i_q_data.item.dx) : i_q_data.item.dx;
            end else begin
                pm = i_q_data.item.dy[DW-1] ? DW'(-i_q_data.item.dy) : i_q_data.item.dy;
            end
            n_s0_div[e].rem  = RW'(qm) << FB;
            n_s0_div[e].quo  = '0;
            n_s0_div[e].pmag = pm;
            n_s0_div[e].neg  = i_q_data.q[e][DW-1] ^ i_q_data.item.pneg[e];
            n_s0_div[e].ovf  = ({2'b00, qm} >= {pm, 2'b00});
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        t_div          d;
        logic [RW-1:0] cand;
        for (int i = 0; i < QB; i++) begin
            for (int e = 0; e < NE; e++) begin
                d    = (i == 0) ? r_s0_div[e] : r_dv_div[i-1][e];
                cand = RW'(d.pmag) << (QB - 1 - i);
                if (d.rem >= cand) begin
                    d.rem              = d.rem - cand;
                    d.quo[QB - 1 - i]  = 1'b1;
                end
                n_dv_div[i][e] = d;
            end
        end
    end

    // saturate quotient to [-1, 2]
    always_comb begin
        t_div          d;
        logic [UW-1:0] m;
        for (int e = 0; e < NE; e++) begin
            d = r_dv_div[QB-1][e];
            m = {1'b0, d.quo};
            if (d.neg) begin
                if (d.ovf || m > U_ONE) begin
                    m = U_ONE;
                end
                n_st_u[e] = -$signed(m);
            end else begin
                if (d.ovf || m > U_TWO) begin
                    m = U_TWO;
                end
                n_st_u[e] = $signed(m);
            end
        end
    end

    // walk the boundaries in order, tightening entry and exit
    always_comb begin
        n_cb_ok    = !r_st_item.prej;
        n_cb_entry = '0;
        n_cb_exit  = $signed(U_ONE);
        for (int e = 0; e < NE; e++) begin
            if (!r_st_item.skip[e]) begin
                if (r_st_item.pneg[e]) begin
                    if (r_st_u[e] > n_cb_exit) begin
                        n_cb_ok = 1'b0;
                    end else if (r_st_u[e] > n_cb_entry) begin
                        n_cb_entry = r_st_u[e];
                    end
                end else begin
                    if (r_st_u[e] < n_cb_entry) begin
                        n_cb_ok = 1'b0;
                    end else if (r_st_u[e] < n_cb_exit) begin
                        n_cb_exit = r_st_u[e];
                    end
                end
            end
        end
    end

    // final coordinates; rejected segments pass through
    always_comb begin
        logic [DW-1:0] ex;
        logic [DW-1:0] ey;
        ex = DW'(r_ml_item.x0) + r_ml_item.dx;
        ey = DW'(r_ml_item.y0) + r_ml_item.dy;
        if (r_ml_ok) begin
            n_o_sx = clip_coord(r_ml_item.x0, r_ml_p[0]);
            n_o_sy = clip_coord(r_ml_item.y0, r_ml_p[1]);
            n_o_ex = clip_coord(r_ml_item.x0, r_ml_p[2]);
            n_o_ey = clip_coord(r_ml_item.y0, r_ml_p[3]);
        end else begin
            n_o_sx = r_ml_item.x0;
            n_o_sy = r_ml_item.y0;
            n_o_ex = ex[CW-1:0];
            n_o_ey = ey[CW-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_dv_v <= '0;
            r_st_v <= 1'b0;
            r_cb_v <= 1'b0;
            r_ml_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_s0_v <= !i_q_stat.empty;
            r_dv_v <= {r_dv_v[QB-2:0], r_s0_v};
            r_st_v <= r_dv_v[QB-1];
            r_cb_v <= r_st_v;
            r_ml_v <= r_cb_v;
            r_ov   <= r_ml_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_item <= i_q_data.item;
            r_s0_div  <= n_s0_div;
            for (int i = 0; i < QB; i++) begin
                r_dv_item[i] <= (i == 0) ? r_s0_item : r_dv_item[i-1];
            end
            r_dv_div   <= n_dv_div;
            r_st_item  <= r_dv_item[QB-1];
            r_st_u     <= n_st_u;
            r_cb_item  <= r_st_item;
            r_cb_ok    <= n_cb_ok;
            r_cb_entry <= n_cb_entry;
            r_cb_exit  <= n_cb_exit;
            r_ml_item  <= r_cb_item;
            r_ml_ok    <= r_cb_ok;
            r_ml_p[0]  <= r_cb_entry * r_cb_item.dx;
            r_ml_p[1]  <= r_cb_entry * r_cb_item.dy;
            r_ml_p[2]  <= r_cb_exit * r_cb_item.dx;
            r_ml_p[3]  <= r_cb_exit * r_cb_item.dy;
            r_o_vis    <= r_ml_ok;
            r_o_sx     <= n_o_sx;
            r_o_sy     <= n_o_sy;
            r_o_ex     <= n_o_ex;
            r_o_ey     <= n_o_ey;
        end
    end

    assign empty          = !r_ov;
    assign o_visible      = r_o_vis;
    assign o_clip_start_x = r_o_sx;
    assign o_clip_start_y = r_o_sy;
    assign o_clip_end_x   = r_o_ex;
    assign o_clip_end_y   = r_o_ey;

endmodule
